[sv/max_heap_priority_queue_core_assert.svh]
// assertion macros shared by the priority queue
`ifndef MAX_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define MHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/mhpq_pkg.sv]
package mhpq_pkg;

   localparam int DATA_W      = 32;
   localparam int COUNT_OUT_W = 5;
   localparam int STATUS_W    = 2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic                     ins;
      logic                     rem;
      logic signed [DATA_W-1:0] key;
   } cell_cmd_type;

endpackage

[sv/max_heap_priority_queue_core.sv]
// channel  dir  tdata (low bit up)                        tuser
// req      in   value[31:0]                              op[0]
// rsp      out  removed_value, top_value, element_count   status[1:0]
//
// one request per cycle unless rsp stalls; cells shift or open a gap in one step
// the result is registered and shows in the cycle after the request transfer
// a new request is taken while the result is consumed in the same cycle
// reset clears the element count and the result valid
// the row holds values sorted largest first, so the maximum sits in the first cell
module max_heap_priority_queue_core
   import mhpq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic [0:0]  req_tuser,   // op[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // removed_value[31:0], top_value[63:32],
                                    // element_count[68:64], zero fill[71:69]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

`include "max_heap_priority_queue_core_assert.svh"

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   logic [CW-1:0] count_ff, count_in;
   logic          accept, op, ins_ok, rem_ok;
   cell_cmd_type  cmd;

   logic signed [DATA_W-1:0] cell_val [CAPACITY];
   logic signed [DATA_W-1:0] cell_nxt [CAPACITY];
   logic                     cell_gt  [CAPACITY];

   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic signed [DATA_W-1:0]   removed_ff, removed_in;
   logic signed [DATA_W-1:0]   top_ff, top_in;
   logic [COUNT_OUT_W-1:0]     cnt_out_ff, cnt_out_in;
   logic [STATUS_W-1:0]        status_ff, status_in;
   logic [CW+COUNT_OUT_W-1:0]  count_wide;

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign op         = req_tuser[0];
   assign ins_ok     = accept && (op == OP_INSERT) && (count_ff != CAP_CNT);
   assign rem_ok     = accept && (op == OP_REMOVE) && (count_ff != '0);

   assign cmd.ins = ins_ok;
   assign cmd.rem = rem_ok;
   assign cmd.key = req_tdata;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic signed [DATA_W-1:0] lv, rv;
         logic                     lg;
         if (i == 0) begin : g_first
            assign lv = '0;
            assign lg = 1'b0;
         end else begin : g_mid
            assign lv = cell_val[i-1];
            assign lg = cell_gt[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign rv = '0;
         end else begin : g_inner
            assign rv = cell_val[i+1];
         end
         mhpq_cell u_cell (
            .clock     (clock),
            .cmd       (cmd),
            .occ       (CW'(i) < count_ff),
            .left_val  (lv),
            .left_gt   (lg),
            .right_val (rv),
            .val       (cell_val[i]),
            .val_nxt   (cell_nxt[i]),
            .gt        (cell_gt[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ins_ok) begin
         count_in = count_ff + 1'b1;
      end else if (rem_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign count_wide = (CW + COUNT_OUT_W)'(count_in);

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      removed_in    = removed_ff;
      top_in        = top_ff;
      cnt_out_in    = cnt_out_ff;
      status_in     = status_ff;
      if (accept) begin
         rsp_tvalid_in = 1'b1;
         removed_in    = rem_ok ? cell_val[0] : '0;
         top_in        = (count_in != '0) ? cell_nxt[0] : '0;
         cnt_out_in    = count_wide[COUNT_OUT_W-1:0];
         if (op == OP_INSERT && !ins_ok) begin
            status_in = ST_FULL;
         end else if (op == OP_REMOVE && !rem_ok) begin
            status_in = ST_EMPTY;
         end else begin
            status_in = ST_OK;
         end
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      removed_ff <= removed_in;
      top_ff     <= top_in;
      cnt_out_ff <= cnt_out_in;
      status_ff  <= status_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {3'b000, cnt_out_ff, top_ff, removed_ff};
   assign rsp_tuser  = status_ff;

   `MHPQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CAP_CNT, "count beyond capacity")
   `MHPQ_ASSERT_NOW(a_row_order, count_ff >= CW'(2), cell_val[0] >= cell_val[1], "row out of order")
   `MHPQ_ASSERT_NEXT(a_insert_count, ins_ok, count_ff == CW'($past(count_ff) + 1'b1), "insert count")
   `MHPQ_ASSERT_NOW(a_full_status, rsp_tvalid_ff && status_ff == ST_FULL, count_ff == CAP_CNT, "full status")

endmodule

[sv/mhpq_cell.sv]
module mhpq_cell
   import mhpq_pkg::*;
(
   input  logic                     clock,
   input  cell_cmd_type             cmd,
   input  logic                     occ,
   input  logic signed [DATA_W-1:0] left_val,
   input  logic                     left_gt,
   input  logic signed [DATA_W-1:0] right_val,
   output logic signed [DATA_W-1:0] val,
   output logic signed [DATA_W-1:0] val_nxt,
   output logic                     gt
);

   logic signed [DATA_W-1:0] val_ff;
   logic signed [DATA_W-1:0] val_in;

   // key belongs at or before this cell; monotonic along the sorted row
   assign gt = !occ || (cmd.key > val_ff);

   always_comb begin
      val_in = val_ff;
      if (cmd.ins) begin
         if (left_gt) begin
            val_in = left_val;
         end else if (gt) begin
            val_in = cmd.key;
         end
      end else if (cmd.rem) begin
         val_in = right_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val     = val_ff;
   assign val_nxt = val_in;

endmodule
